// ===== hw/rtl/c128_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Code 128 encoder package
// Symbol codes, code set codes, the run descriptor shared by the front, the
// queue and the back, and the bar and space pattern table.
// ----------------------------------------------------------------------------
package c128_pkg;

    localparam int RUN_MAX     = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] SYM_START_A = 7'd103;
    localparam logic [6:0] SYM_START_B = 7'd104;
    localparam logic [6:0] SYM_START_C = 7'd105;
    localparam logic [6:0] SYM_CODE_A  = 7'd101;
    localparam logic [6:0] SYM_CODE_B  = 7'd100;
    localparam logic [6:0] SYM_CODE_C  = 7'd99;
    localparam logic [6:0] SYM_STOP    = 7'd106;
    localparam logic [6:0] CHECK_MOD   = 7'd103;

    localparam logic [1:0] SET_NONE = 2'd0;
    localparam logic [1:0] SET_A    = 2'd1;
    localparam logic [1:0] SET_B    = 2'd2;
    localparam logic [1:0] SET_C    = 2'd3;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // All symbols that one message byte settles, in emission order.
    typedef struct packed {
        logic [2:0]                 count;
        logic [RUN_MAX-1:0][1:0]    kinds;
        logic [RUN_MAX-1:0][6:0]    syms;
    } t_run;

    // One hex digit per element, first element in the top digit; a zero
    // digit marks an element that is not there.
    localparam logic [27:0] PATTERN_TAB [0:106] = '{
        28'h2122220, 28'h2221220, 28'h2222210, 28'h1212230,
        28'h1213220, 28'h1312220, 28'h1222130, 28'h1223120,
        28'h1322120, 28'h2212130, 28'h2213120, 28'h2312120,
        28'h1122320, 28'h1221320, 28'h1222310, 28'h1132220,
        28'h1231220, 28'h1232210, 28'h2232110, 28'h2211320,
        28'h2212310, 28'h2132120, 28'h2231120, 28'h3121310,
        28'h3112220, 28'h3211220, 28'h3212210, 28'h3122120,
        28'h3221120, 28'h3222110, 28'h2121230, 28'h2123210,
        28'h2321210, 28'h1113230, 28'h1311230, 28'h1313210,
        28'h1123130, 28'h1321130, 28'h1323110, 28'h2113130,
        28'h2311130, 28'h2313110, 28'h1121330, 28'h1123310,
        28'h1321310, 28'h1131230, 28'h1133210, 28'h1331210,
        28'h3131210, 28'h2113310, 28'h2311310, 28'h2131130,
        28'h2133110, 28'h2131310, 28'h3111230, 28'h3113210,
        28'h3311210, 28'h3121130, 28'h3123110, 28'h3321110,
        28'h3141110, 28'h2214110, 28'h4311110, 28'h1112240,
        28'h1114220, 28'h1211240, 28'h1214210, 28'h1411220,
        28'h1412210, 28'h1122140, 28'h1124120, 28'h1221140,
        28'h1224110, 28'h1421120, 28'h1422110, 28'h2412110,
        28'h2211140, 28'h4131110, 28'h2411120, 28'h1341110,
        28'h1112420, 28'h1211420, 28'h1212410, 28'h1142120,
        28'h1241120, 28'h1242110, 28'h4112120, 28'h4211120,
        28'h4212110, 28'h2121410, 28'h2141210, 28'h4121210,
        28'h1111430, 28'h1113410, 28'h1311410, 28'h1141130,
        28'h1143110, 28'h4111130, 28'h4113110, 28'h1131410,
        28'h1141310, 28'h3111410, 28'h4111310, 28'h2114120,
        28'h2112140, 28'h2112320, 28'h2331112
    };

    function automatic logic [20:0] f_widths(input logic [6:0] sym);
        logic [20:0] w;
        logic [27:0] p;
        w = '0;
        p = '0;
        if (sym <= SYM_STOP) begin
            p = PATTERN_TAB[sym];
        end
        for (int k = 0; k < 7; k++) begin
            w[3*k +: 3] = p[24-4*k +: 3];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/c128_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Code 128 front end
// Accepts message bytes, tracks the code set and the held digit, and turns
// each byte into a run descriptor of the symbols it settles.
// ----------------------------------------------------------------------------
module c128_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_last_char,
    input  wire logic          i_full,
    output logic               o_push,
    output c128_pkg::t_run     o_run
);
    import c128_pkg::*;

    typedef struct packed {
        logic [1:0] cs;
        t_run       run;
    } t_build;

    logic [1:0] r_code_set, n_code_set;
    logic       r_digit_waiting, n_digit_waiting;
    logic [3:0] r_waiting_digit, n_waiting_digit;
    logic       accept;
    logic [6:0] ch7;
    logic       is_digit;
    t_build     b;

    function automatic t_build f_add(input t_build bi, input logic [1:0] kind,
                                     input logic [6:0] sym);
        t_build r;
        r = bi;
        if (bi.run.count < 3'(RUN_MAX)) begin
            r.run.kinds[bi.run.count] = kind;
            r.run.syms[bi.run.count]  = sym;
            r.run.count               = bi.run.count + 3'd1;
        end
        return r;
    endfunction

    function automatic t_build f_single(input t_build bi, input logic [6:0] ch);
        t_build r;
        logic   ctl;
        r   = bi;
        ctl = (ch < 7'd32);
        if (r.cs == SET_NONE) begin
            if (ctl) begin
                r    = f_add(r, KIND_START, SYM_START_A);
                r.cs = SET_A;
            end else begin
                r    = f_add(r, KIND_START, SYM_START_B);
                r.cs = SET_B;
            end
        end
        if (ctl && r.cs != SET_A) begin
            r    = f_add(r, KIND_DATA, SYM_CODE_A);
            r.cs = SET_A;
        end else if ((ch >= 7'd64 && r.cs != SET_B) || r.cs == SET_C) begin
            r    = f_add(r, KIND_DATA, SYM_CODE_B);
            r.cs = SET_B;
        end
        r = f_add(r, KIND_DATA, ctl ? ch + 7'd64 : ch - 7'd32);
        return r;
    endfunction

    function automatic t_build f_pair(input t_build bi, input logic [3:0] d1,
                                      input logic [3:0] d2);
        t_build r;
        r = bi;
        if (r.cs == SET_NONE) begin
            r    = f_add(r, KIND_START, SYM_START_C);
            r.cs = SET_C;
        end else if (r.cs != SET_C) begin
            r    = f_add(r, KIND_DATA, SYM_CODE_C);
            r.cs = SET_C;
        end
        r = f_add(r, KIND_DATA, {3'd0, d1} * 7'd10 + {3'd0, d2});
        return r;
    endfunction

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign ch7      = i_char_code[6:0];
    assign is_digit = (ch7 >= 7'd48) && (ch7 <= 7'd57);

    always_comb begin
        b.cs            = r_code_set;
        b.run           = '0;
        n_digit_waiting = r_digit_waiting;
        n_waiting_digit = r_waiting_digit;
        if (!i_char_code[7]) begin
            if (is_digit) begin
                if (r_digit_waiting) begin
                    b               = f_pair(b, r_waiting_digit, ch7[3:0]);
                    n_digit_waiting = 1'b0;
                end else if (i_last_char) begin
                    b = f_single(b, ch7);
                end else begin
                    n_digit_waiting = 1'b1;
                    n_waiting_digit = ch7[3:0];
                end
            end else begin
                if (r_digit_waiting) begin
                    b               = f_single(b, {3'b011, r_waiting_digit});
                    n_digit_waiting = 1'b0;
                end
                b = f_single(b, ch7);
            end
        end
        n_code_set = b.cs;
        if (i_last_char) begin
            if (n_digit_waiting) begin
                b = f_single(b, {3'b011, n_waiting_digit});
            end
            b               = f_add(b, KIND_CHECK, 7'd0);
            b               = f_add(b, KIND_STOP, SYM_STOP);
            n_code_set      = SET_NONE;
            n_digit_waiting = 1'b0;
            n_waiting_digit = 4'd0;
        end
    end

    assign o_push = accept && (b.run.count != 3'd0);
    assign o_run  = b.run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_set      <= SET_NONE;
            r_digit_waiting <= 1'b0;
            r_waiting_digit <= 4'd0;
        end else if (accept) begin
            r_code_set      <= n_code_set;
            r_digit_waiting <= n_digit_waiting;
            r_waiting_digit <= n_waiting_digit;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/c128_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Code 128 run queue
// A short queue of run descriptors between the front and the back.
// ----------------------------------------------------------------------------
module c128_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  c128_pkg::t_run     i_data,
    output logic               o_full,
    output logic               o_valid,
    output c128_pkg::t_run     o_data,
    input  wire logic          i_pop
);
    import c128_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_run               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/c128_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Code 128 back end
// Steps through each run one symbol a cycle unless stalled, keeps the weighted
// modulo-103 checksum in a three-stage pipeline and drives the result register.
// ----------------------------------------------------------------------------
module c128_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  c128_pkg::t_run     i_run,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [6:0]         o_symbol_value,
    output logic [20:0]        o_bar_widths,
    output logic [2:0]         o_element_count,
    output logic               o_end_of_message,
    output logic               o_last_in_run
);
    import c128_pkg::*;

    logic [2:0]     r_idx;
    logic           r_out_valid;
    logic [6:0]     r_acc;
    logic [6:0]     r_w;
    logic           r_v1, r_v2, r_v3;
    logic [13:0]    r_p, r_p2;
    logic [7:0]     r_q;
    logic [6:0]     r_r;

    logic [1:0]     kind;
    logic [6:0]     sym;
    logic [6:0]     value;
    logic           busy;
    logic           issue;
    logic           last;
    logic [23:0]    recip;
    logic [14:0]    rem;
    logic [7:0]     sum;

    assign kind  = i_run.kinds[r_idx];
    assign sym   = i_run.syms[r_idx];
    assign busy  = r_v1 || r_v2 || r_v3;
    assign issue = i_valid && (!r_out_valid || i_ready) && !(kind == KIND_CHECK && busy);
    assign last  = (r_idx == i_run.count - 3'd1);
    assign value = (kind == KIND_CHECK) ? r_acc : sym;
    assign o_pop = issue && last;

    // Reciprocal of 103 scaled by 2^16, rounded down: the quotient is exact or
    // one low, so the remainder needs a single correction.
    assign recip = 24'(r_p) * 24'd636;
    assign rem   = 15'(r_p2) - 15'(r_q) * 15'(CHECK_MOD);
    assign sum   = {1'b0, r_acc} + {1'b0, r_r};

    always_ff @(posedge i_clk) begin
        if (issue) begin
            o_symbol_value   <= value;
            o_bar_widths     <= f_widths(value);
            o_element_count  <= (value == SYM_STOP) ? 3'd7 : 3'd6;
            o_end_of_message <= (kind == KIND_STOP);
            o_last_in_run    <= last;
        end
        r_p  <= 14'(sym) * 14'(r_w);
        r_p2 <= r_p;
        r_q  <= recip[23:16];
        r_r  <= (rem >= 15'(CHECK_MOD)) ? 7'(rem - 15'(CHECK_MOD)) : 7'(rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
            r_acc       <= 7'd0;
            r_w         <= 7'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            if (issue) begin
                r_out_valid <= 1'b1;
                r_idx       <= last ? 3'd0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= issue && (kind == KIND_DATA);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (issue && kind == KIND_START) begin
                r_acc <= sym - CHECK_MOD;
                r_w   <= 7'd1;
            end else if (issue && kind == KIND_STOP) begin
                r_acc <= 7'd0;
                r_w   <= 7'd0;
            end else begin
                if (issue && kind == KIND_DATA) begin
                    r_w <= (r_w == CHECK_MOD - 7'd1) ? 7'd0 : r_w + 7'd1;
                end
                if (r_v3) begin
                    r_acc <= (sum >= {1'b0, CHECK_MOD}) ? 7'(sum - {1'b0, CHECK_MOD})
                                                        : 7'(sum);
                end
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/code128_symbol_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Code 128 symbol encoder
// Turns a stream of message bytes into Code 128 symbols with automatic code
// set selection, digit pairing, checksum and stop, one symbol per result.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+---------------------------------------------
//  input    | i_valid / o_ready  | i_char_code, i_last_char
//  output   | o_valid / i_ready  | o_symbol_value, o_bar_widths,
//           |                    | o_element_count, o_end_of_message,
//           |                    | o_last_in_run
//
// A byte that settles n symbols (0 to 6) occupies the back end for its n
// symbols; the check symbol may wait while the checksum pipeline drains. The
// front end takes a byte every cycle while the two-entry run queue has room,
// so a byte is accepted while earlier results are still being sent. Reset is
// synchronous and active low; it clears the code set, the held digit, the
// checksum and the queue, with no clearing pass. A stall on the output holds
// the result register and, once the queue fills, lowers o_ready.
//
// The front end decides the whole symbol sequence of a byte combinationally,
// since the code set and the held digit depend only on the bytes. Only the
// checksum depends on the symbols sent, and it is kept in the back end.
module code128_symbol_encoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_last_char,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [6:0]         o_symbol_value,
    output logic [20:0]        o_bar_widths,
    output logic [2:0]         o_element_count,
    output logic               o_end_of_message,
    output logic               o_last_in_run
);
    import c128_pkg::*;

    // Run descriptors from the front end and the head of the queue.
    t_run   push_run;
    t_run   head_run;
    logic   push;
    logic   full;
    logic   head_valid;
    logic   pop;

    c128_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_full      (full),
        .o_push      (push),
        .o_run       (push_run)
    );

    // The queue lets the front end keep taking bytes while the back end is
    // still sending the symbols of an earlier byte or is stalled.
    c128_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_run),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_run),
        .i_pop   (pop)
    );

    // The back end sends one symbol per cycle unless stalled and retires a
    // descriptor with its last symbol, which carries o_last_in_run.
    c128_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (head_valid),
        .i_run            (head_run),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_symbol_value   (o_symbol_value),
        .o_bar_widths     (o_bar_widths),
        .o_element_count  (o_element_count),
        .o_end_of_message (o_end_of_message),
        .o_last_in_run    (o_last_in_run)
    );

endmodule
`default_nettype wire
